// ===== rtl/aer_pkg.sv =====
package aer_pkg;

    // Default depth of the queue between the parser and the field decoder.
    localparam int QUEUE_DEPTH = 4;

    // Word layout of the event stream.
    localparam logic [5:0]  TOP6_TS   = 6'b100000;
    localparam logic [5:0]  TOP6_WRAP = 6'b100010;
    localparam logic [31:0] WRAP_STEP = 32'h0100_0000;
    localparam logic [15:0] SYNC_HIGH = 16'h0001;

    // Parse phase of the stream.
    typedef enum logic [1:0] {
        PH_TS     = 2'd0,
        PH_FORCED = 2'd1,
        PH_ADDR   = 2'd2
    } t_phase;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_EVENT     = 3'd0,
        ST_SYNC      = 3'd1,
        ST_MISS_TS   = 3'd2,
        ST_MISS_ADDR = 3'd3,
        ST_CORRUPT   = 3'd4
    } t_status;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_X_MASK     = 3'd0,
        CFG_X_SHIFT    = 3'd1,
        CFG_Y_MASK     = 3'd2,
        CFG_Y_SHIFT    = 3'd3,
        CFG_POL_MASK   = 3'd4,
        CFG_POL_SHIFT  = 3'd5,
        CFG_EYE_MASK   = 3'd6,
        CFG_EYE_SHIFT  = 3'd7
    } t_cfg_index;

    // Classified item handed from the parser to the decoder.
    typedef struct packed {
        t_status     status;
        logic [15:0] addr;
        logic [31:0] stamp;
    } t_entry;

endpackage

// ===== rtl/aer_front.sv =====
module aer_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [31:0]        i_word,
    output logic               o_emit,
    output aer_pkg::t_entry    o_entry
);

    aer_pkg::t_phase r_phase, n_phase;
    logic [31:0]     r_wrap, n_wrap;
    logic [31:0]     r_last, n_last;

    logic        w_flag;
    logic        w_marker;
    logic        w_wrap;
    logic [31:0] w_stamp;

    // Word classification in a timestamp slot.
    assign w_flag   = i_word[31];
    assign w_marker = w_flag && (i_word[31:26] != aer_pkg::TOP6_TS);
    assign w_wrap   = (i_word[31:26] == aer_pkg::TOP6_WRAP);
    assign w_stamp  = {6'b0, i_word[25:0]} + r_wrap;

    // Next parse state. The address slot and the timestamp slot advance alike:
    // a word with the flag set is parsed as a timestamp word in both.
    always_comb begin
        n_phase = r_phase;
        n_wrap  = r_wrap;
        n_last  = r_last;
        if (r_phase == aer_pkg::PH_FORCED) begin
            n_last  = w_stamp;
            n_phase = aer_pkg::PH_ADDR;
        end else if (!w_flag) begin
            n_phase = aer_pkg::PH_TS;
        end else if (w_marker) begin
            if (w_wrap) begin
                n_wrap = r_wrap + aer_pkg::WRAP_STEP;
            end
            n_phase = aer_pkg::PH_FORCED;
        end else begin
            n_last  = w_stamp;
            n_phase = aer_pkg::PH_ADDR;
        end
    end

    // Result classification; the time is always that of the open pair.
    always_comb begin
        o_emit         = 1'b0;
        o_entry.status = aer_pkg::ST_EVENT;
        o_entry.addr   = i_word[15:0];
        o_entry.stamp  = r_last;
        unique case (r_phase)
            aer_pkg::PH_FORCED: begin
                o_emit = 1'b0;
            end
            aer_pkg::PH_ADDR: begin
                o_emit = 1'b1;
                if (w_flag) begin
                    o_entry.status = aer_pkg::ST_MISS_ADDR;
                end else if (i_word[31:16] > aer_pkg::SYNC_HIGH) begin
                    o_entry.status = aer_pkg::ST_CORRUPT;
                end else if (i_word[31:16] == aer_pkg::SYNC_HIGH) begin
                    o_entry.status = aer_pkg::ST_SYNC;
                end else begin
                    o_entry.status = aer_pkg::ST_EVENT;
                end
            end
            default: begin
                o_emit         = !w_flag;
                o_entry.status = aer_pkg::ST_MISS_TS;
            end
        endcase
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= aer_pkg::PH_TS;
            r_wrap  <= '0;
            r_last  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_wrap  <= n_wrap;
            r_last  <= n_last;
        end
    end

endmodule

// ===== rtl/aer_queue.sv =====
module aer_queue #(
    parameter int DEPTH = aer_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  aer_pkg::t_entry    i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output aer_pkg::t_entry    o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aer_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    // A lone push grows the count by one.
    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    // Pointers are equal whenever the queue is empty.
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");

endmodule

// ===== rtl/aer_back.sv =====
module aer_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_head_valid,
    input  aer_pkg::t_entry    i_head,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [2:0]         o_status,
    output logic [15:0]        o_x_coord,
    output logic [15:0]        o_y_coord,
    output logic               o_polarity_on,
    output logic [15:0]        o_eye_index,
    output logic [31:0]        o_event_time
);

    logic [15:0] r_x_mask, r_y_mask, r_pol_mask, r_eye_mask;
    logic [3:0]  r_x_shift, r_y_shift, r_pol_shift, r_eye_shift;

    logic        r_valid;
    logic [2:0]  r_status;
    logic [15:0] r_x, r_y, r_eye;
    logic        r_pol;
    logic [31:0] r_time;

    logic        is_event;
    logic [15:0] x_field, y_field, pol_field, eye_field;

    // Configuration registers; the write channel never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_mask    <= 16'h00FE;
            r_x_shift   <= 4'd1;
            r_y_mask    <= 16'h7F00;
            r_y_shift   <= 4'd8;
            r_pol_mask  <= 16'h0001;
            r_pol_shift <= 4'd0;
            r_eye_mask  <= 16'h8000;
            r_eye_shift <= 4'd15;
        end else if (i_cfg_valid) begin
            unique case (aer_pkg::t_cfg_index'(i_cfg_index))
                aer_pkg::CFG_X_MASK:    r_x_mask    <= i_cfg_data;
                aer_pkg::CFG_X_SHIFT:   r_x_shift   <= i_cfg_data[3:0];
                aer_pkg::CFG_Y_MASK:    r_y_mask    <= i_cfg_data;
                aer_pkg::CFG_Y_SHIFT:   r_y_shift   <= i_cfg_data[3:0];
                aer_pkg::CFG_POL_MASK:  r_pol_mask  <= i_cfg_data;
                aer_pkg::CFG_POL_SHIFT: r_pol_shift <= i_cfg_data[3:0];
                aer_pkg::CFG_EYE_MASK:  r_eye_mask  <= i_cfg_data;
                aer_pkg::CFG_EYE_SHIFT: r_eye_shift <= i_cfg_data[3:0];
                default:                r_x_mask    <= r_x_mask;
            endcase
        end
    end

    // Field extraction from the low address half.
    assign is_event  = (i_head.status == aer_pkg::ST_EVENT) ||
                       (i_head.status == aer_pkg::ST_SYNC);
    assign x_field   = (i_head.addr & r_x_mask) >> r_x_shift;
    assign y_field   = (i_head.addr & r_y_mask) >> r_y_shift;
    assign pol_field = (i_head.addr & r_pol_mask) >> r_pol_shift;
    assign eye_field = (i_head.addr & r_eye_mask) >> r_eye_shift;

    // The output register reloads when empty or when its item leaves.
    assign o_take = i_head_valid && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_status <= i_head.status;
            r_x      <= is_event ? x_field : '0;
            r_y      <= is_event ? y_field : '0;
            r_pol    <= is_event && (pol_field != '0);
            r_eye    <= is_event ? eye_field : '0;
            r_time   <= i_head.stamp;
        end
    end

    assign o_empty       = !r_valid;
    assign o_status      = r_status;
    assign o_x_coord     = r_x;
    assign o_y_coord     = r_y;
    assign o_polarity_on = r_pol;
    assign o_eye_index   = r_eye;
    assign o_event_time  = r_time;

endmodule

// ===== rtl/aer_event_word_decoder.sv =====
// Event stream word decoder.
// Input side is a queue write port: a 32-bit stream word is taken at a clock
// edge with push high and full low. Result side is a queue read port: while
// empty is low the oldest result sits on the o_ ports, and pop takes it.
// Not every word gives a result; words that only set up a timestamp or a
// marker are absorbed by the parser.
// The parser takes one word per cycle while full is low and hands each result
// to a small queue of QUEUE_DEPTH items; the decoder applies the field masks
// and shifts and registers the result. A result passes through the queue and
// then the output register. Sustained rate is one word per cycle while not full.
// When the receiver stalls, results pile up in the queue and the output
// register; full rises once both are occupied, and nothing is dropped.
// Configuration writes go through a valid/ready channel that is always
// ready, and are meant to happen while the block is idle.
// Synchronous reset returns the parser to expecting a timestamp, clears the
// wrap offset and last timestamp, empties the queue and loads the register
// defaults. No clearing pass is needed after reset.
module aer_event_word_decoder #(
    parameter int QUEUE_DEPTH = aer_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_stream_word,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_x_coord,
    output logic [15:0] o_y_coord,
    output logic        o_polarity_on,
    output logic [15:0] o_eye_index,
    output logic [31:0] o_event_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic            accept;
    logic            emit;
    aer_pkg::t_entry front_entry;
    aer_pkg::t_entry head_entry;
    logic            head_empty;
    logic            take;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    // Parser: phase, wrap offset and timestamp tracking.
    aer_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_stream_word),
        .o_emit   (emit),
        .o_entry  (front_entry)
    );

    // Queue between parser and decoder.
    aer_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && emit),
        .i_data  (front_entry),
        .o_full  (full),
        .i_pop   (take),
        .o_empty (head_empty),
        .o_data  (head_entry)
    );

    // Decoder and output register.
    aer_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_head_valid  (!head_empty),
        .i_head        (head_entry),
        .o_take        (take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_status      (o_status),
        .o_x_coord     (o_x_coord),
        .o_y_coord     (o_y_coord),
        .o_polarity_on (o_polarity_on),
        .o_eye_index   (o_eye_index),
        .o_event_time  (o_event_time)
    );

endmodule
